// ===== sv/cpc_pkg.sv =====
// cpc_pkg: fixed widths and stage counts of the capsule pair contact test.
// No dependencies; imported by capsule_pair_contact_top.
package cpc_pkg;

    localparam int LEN_W    = 30;
    localparam int RSUM_W   = 31;
    localparam int MAG_W    = 31;
    localparam int SQ_W     = 62;
    localparam int DIST_W   = 31;
    localparam int PAIR_W   = 32;
    localparam int HALF_W   = 16;
    localparam int MIX_W    = 32;
    localparam int MIX_RT_W = 16;
    localparam int NORM_W   = 18;
    localparam int DEPTH_W  = 31;
    localparam int SQ_STG   = SQ_W / 2;
    localparam int MIX_STG  = MIX_W / 2;

endpackage

// ===== sv/capsule_pair_contact_top.sv =====
// capsule_pair_contact_top: pipelined contact test of two vertical capsules.
// Depends on cpc_pkg, cpc_isqrt, cpc_div.
//
// channel  | handshake         | payload
// ---------+-------------------+--------------------------------------------
// input    | start, busy       | i_a_base_*, i_b_base_*, heights, radii, pairs
// result   | o_strobe          | o_hit, o_normal_*, o_contact_*, o_depth, o_mixed_*
//
// One transfer per cycle; busy stays low. A result passes through 6 geometry stages,
// 31 root stages, one numerator stage, FRAC_BITS + 1 divider stages and the output
// register.
// Reset clears only the valid line; the receiver cannot stall, so nothing ever waits.
module capsule_pair_contact_top
    import cpc_pkg::*;
#(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] i_a_base_x,
    input  logic signed [COORD_BITS-1:0] i_a_base_y,
    input  logic signed [COORD_BITS-1:0] i_a_base_z,
    input  logic signed [COORD_BITS-1:0] i_b_base_x,
    input  logic signed [COORD_BITS-1:0] i_b_base_y,
    input  logic signed [COORD_BITS-1:0] i_b_base_z,
    input  logic [LEN_W-1:0]             i_a_height,
    input  logic [LEN_W-1:0]             i_b_height,
    input  logic [LEN_W-1:0]             i_a_radius,
    input  logic [LEN_W-1:0]             i_b_radius,
    input  logic [PAIR_W-1:0]            i_friction_pair,
    input  logic [PAIR_W-1:0]            i_restitution_pair,
    output logic                         o_strobe,
    output logic                         o_hit,
    output logic signed [NORM_W-1:0]     o_normal_x,
    output logic signed [NORM_W-1:0]     o_normal_y,
    output logic signed [NORM_W-1:0]     o_normal_z,
    output logic signed [COORD_BITS-1:0] o_contact_x,
    output logic signed [COORD_BITS-1:0] o_contact_y,
    output logic signed [COORD_BITS-1:0] o_contact_z,
    output logic [DEPTH_W-1:0]           o_depth,
    output logic [HALF_W-1:0]            o_mixed_friction,
    output logic [HALF_W-1:0]            o_mixed_restitution
);

    localparam int CW      = COORD_BITS;
    localparam int FB      = FRAC_BITS;
    localparam int YW      = ((CW > LEN_W) ? CW : LEN_W) + 2;
    localparam int NUM_W   = DIST_W + 1 + FB;
    localparam int Q_W     = FB + 1;
    localparam int LAT     = 6 + SQ_STG + 1 + Q_W + 1;
    localparam int MIX_DLY = LAT - 1 - (1 + 2 * MIX_STG);
    localparam int P6_W    = 4 + 4 * MAG_W + 3 * CW;
    localparam int PX_W    = 3 + DEPTH_W + 3 * CW;
    localparam logic signed [YW:0] Y_MAX = {{(YW+2-CW){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [YW:0] Y_MIN = {{(YW+2-CW){1'b1}}, {(CW-1){1'b0}}};

    assign busy = 1'b0;

    logic r_vld [LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LAT; i++) r_vld[i] <= 1'b0;
        end else begin
            r_vld[0] <= start && !busy;
            for (int i = 1; i < LAT; i++) r_vld[i] <= r_vld[i-1];
        end
    end

    // stage 1
    logic signed [CW:0]   r1_u, r1_dx, r1_dz, r1_sx, r1_sz;
    logic signed [CW-1:0] r1_ay, r1_by;
    logic [LEN_W-1:0]     r1_ha, r1_hb;
    logic [RSUM_W-1:0]    r1_rsum;
    logic [MIX_W-1:0]     r1_fp, r1_rp;

    always_ff @(posedge i_clk) begin
        r1_u    <= (CW+1)'(i_b_base_y) - (CW+1)'(i_a_base_y);
        r1_dx   <= (CW+1)'(i_b_base_x) - (CW+1)'(i_a_base_x);
        r1_dz   <= (CW+1)'(i_b_base_z) - (CW+1)'(i_a_base_z);
        r1_sx   <= (CW+1)'(i_a_base_x) + (CW+1)'(i_b_base_x);
        r1_sz   <= (CW+1)'(i_a_base_z) + (CW+1)'(i_b_base_z);
        r1_ay   <= i_a_base_y;
        r1_by   <= i_b_base_y;
        r1_ha   <= i_a_height;
        r1_hb   <= i_b_height;
        r1_rsum <= RSUM_W'(i_a_radius) + RSUM_W'(i_b_radius);
        r1_fp   <= MIX_W'(i_friction_pair[HALF_W-1:0])
                   * MIX_W'(i_friction_pair[PAIR_W-1:HALF_W]);
        r1_rp   <= MIX_W'(i_restitution_pair[HALF_W-1:0])
                   * MIX_W'(i_restitution_pair[PAIR_W-1:HALF_W]);
    end

    // stage 2: clamp segment parameters
    logic signed [63:0] u64, nu64, ha64, hb64;
    logic [LEN_W-1:0]   n_offa, n_offb;

    always_comb begin
        u64    = 64'(r1_u);
        nu64   = -u64;
        ha64   = $signed(64'(r1_ha));
        hb64   = $signed(64'(r1_hb));
        n_offa = (u64 < 0) ? '0 : ((u64 > ha64) ? r1_ha : LEN_W'(u64));
        n_offb = (nu64 < 0) ? '0 : ((nu64 > hb64) ? r1_hb : LEN_W'(nu64));
    end

    logic signed [YW-1:0] r2_cay, r2_cby;
    logic [CW-1:0]        r2_adx, r2_adz;
    logic                 r2_sgx, r2_sgz;
    logic signed [CW-1:0] r2_mx, r2_mz;
    logic [RSUM_W-1:0]    r2_rsum;

    always_ff @(posedge i_clk) begin
        r2_cay  <= YW'(r1_ay) + $signed(YW'(n_offa));
        r2_cby  <= YW'(r1_by) + $signed(YW'(n_offb));
        r2_adx  <= r1_dx[CW] ? CW'(-r1_dx) : CW'(r1_dx);
        r2_adz  <= r1_dz[CW] ? CW'(-r1_dz) : CW'(r1_dz);
        r2_sgx  <= r1_dx[CW];
        r2_sgz  <= r1_dz[CW];
        r2_mx   <= CW'(r1_sx >>> 1);
        r2_mz   <= CW'(r1_sz >>> 1);
        r2_rsum <= r1_rsum;
    end

    // stage 3
    logic signed [YW:0]   r3_dy, r3_sy;
    logic                 r3_rejxz;
    logic [CW-1:0]        r3_adx, r3_adz;
    logic                 r3_sgx, r3_sgz;
    logic signed [CW-1:0] r3_mx, r3_mz;
    logic [RSUM_W-1:0]    r3_rsum;

    always_ff @(posedge i_clk) begin
        r3_dy    <= (YW+1)'(r2_cby) - (YW+1)'(r2_cay);
        r3_sy    <= (YW+1)'(r2_cby) + (YW+1)'(r2_cay);
        r3_rejxz <= (64'(r2_adx) >= 64'(r2_rsum)) || (64'(r2_adz) >= 64'(r2_rsum));
        r3_adx   <= r2_adx;
        r3_adz   <= r2_adz;
        r3_sgx   <= r2_sgx;
        r3_sgz   <= r2_sgz;
        r3_mx    <= r2_mx;
        r3_mz    <= r2_mz;
        r3_rsum  <= r2_rsum;
    end

    // stage 4: reject, saturate y midpoint
    logic [YW:0]        n_ady;
    logic signed [YW:0] n_hy;

    assign n_ady = r3_dy[YW] ? (YW+1)'(-r3_dy) : (YW+1)'(r3_dy);
    assign n_hy  = r3_sy >>> 1;

    logic                 r4_rej;
    logic [MAG_W-1:0]     r4_ax, r4_ay, r4_az;
    logic                 r4_sgx, r4_sgy, r4_sgz;
    logic signed [CW-1:0] r4_mx, r4_my, r4_mz;
    logic [RSUM_W-1:0]    r4_rsum;

    always_ff @(posedge i_clk) begin
        r4_rej  <= r3_rejxz || (64'(n_ady) >= 64'(r3_rsum));
        r4_ax   <= MAG_W'(r3_adx);
        r4_ay   <= MAG_W'(n_ady);
        r4_az   <= MAG_W'(r3_adz);
        r4_sgx  <= r3_sgx;
        r4_sgy  <= r3_dy[YW];
        r4_sgz  <= r3_sgz;
        r4_mx   <= r3_mx;
        r4_mz   <= r3_mz;
        r4_rsum <= r3_rsum;
        if (n_hy > Y_MAX) begin
            r4_my <= CW'(Y_MAX);
        end else if (n_hy < Y_MIN) begin
            r4_my <= CW'(Y_MIN);
        end else begin
            r4_my <= CW'(n_hy);
        end
    end

    // stage 5: squares
    logic [SQ_W-1:0]      r5_qx, r5_qy, r5_qz, r5_rsq;
    logic                 r5_rej;
    logic [MAG_W-1:0]     r5_ax, r5_ay, r5_az;
    logic                 r5_sgx, r5_sgy, r5_sgz;
    logic signed [CW-1:0] r5_mx, r5_my, r5_mz;
    logic [RSUM_W-1:0]    r5_rsum;

    always_ff @(posedge i_clk) begin
        r5_qx   <= SQ_W'(r4_ax) * SQ_W'(r4_ax);
        r5_qy   <= SQ_W'(r4_ay) * SQ_W'(r4_ay);
        r5_qz   <= SQ_W'(r4_az) * SQ_W'(r4_az);
        r5_rsq  <= SQ_W'(r4_rsum) * SQ_W'(r4_rsum);
        r5_rej  <= r4_rej;
        r5_ax   <= r4_ax;
        r5_ay   <= r4_ay;
        r5_az   <= r4_az;
        r5_sgx  <= r4_sgx;
        r5_sgy  <= r4_sgy;
        r5_sgz  <= r4_sgz;
        r5_mx   <= r4_mx;
        r5_my   <= r4_my;
        r5_mz   <= r4_mz;
        r5_rsum <= r4_rsum;
    end

    // stage 6: squared distance
    logic [63:0]          r6_sq;
    logic [SQ_W-1:0]      r6_rsq;
    logic                 r6_rej;
    logic [MAG_W-1:0]     r6_ax, r6_ay, r6_az;
    logic                 r6_sgx, r6_sgy, r6_sgz;
    logic signed [CW-1:0] r6_mx, r6_my, r6_mz;
    logic [RSUM_W-1:0]    r6_rsum;

    always_ff @(posedge i_clk) begin
        r6_sq   <= 64'(r5_qx) + 64'(r5_qy) + 64'(r5_qz);
        r6_rsq  <= r5_rsq;
        r6_rej  <= r5_rej;
        r6_ax   <= r5_ax;
        r6_ay   <= r5_ay;
        r6_az   <= r5_az;
        r6_sgx  <= r5_sgx;
        r6_sgy  <= r5_sgy;
        r6_sgz  <= r5_sgz;
        r6_mx   <= r5_mx;
        r6_my   <= r5_my;
        r6_mz   <= r5_mz;
        r6_rsum <= r5_rsum;
    end

    // distance root
    logic                 n_hit6;
    logic [P6_W-1:0]      w_p6, w_p7;
    logic [DIST_W-1:0]    w_dist;
    logic                 w_hit;
    logic                 w_sgx, w_sgy, w_sgz;
    logic [MAG_W-1:0]     w_ax, w_ay, w_az;
    logic [RSUM_W-1:0]    w_rsum;
    logic signed [CW-1:0] w_mx, w_my, w_mz;

    assign n_hit6 = !r6_rej && (r6_sq < 64'(r6_rsq));
    assign w_p6   = {n_hit6, r6_sgx, r6_sgy, r6_sgz, r6_ax, r6_ay, r6_az, r6_rsum,
                     r6_mx, r6_my, r6_mz};

    cpc_isqrt #(.W(SQ_W), .PASS_W(P6_W)) u_dist (
        .i_clk  (i_clk),
        .i_rad  (SQ_W'(r6_sq)),
        .i_pass (w_p6),
        .o_root (w_dist),
        .o_pass (w_p7)
    );

    assign {w_hit, w_sgx, w_sgy, w_sgz, w_ax, w_ay, w_az, w_rsum, w_mx, w_my, w_mz} = w_p7;

    // numerator stage: |d| scaled plus half the distance for rounding
    logic [NUM_W-1:0]     r7_nx, r7_ny, r7_nz;
    logic [DIST_W-1:0]    r7_dist;
    logic [DEPTH_W-1:0]   r7_depth;
    logic                 r7_hit, r7_dz0;
    logic                 r7_sgx, r7_sgy, r7_sgz;
    logic signed [CW-1:0] r7_mx, r7_my, r7_mz;

    always_ff @(posedge i_clk) begin
        r7_nx    <= (NUM_W'(w_ax) << FB) + NUM_W'(w_dist >> 1);
        r7_ny    <= (NUM_W'(w_ay) << FB) + NUM_W'(w_dist >> 1);
        r7_nz    <= (NUM_W'(w_az) << FB) + NUM_W'(w_dist >> 1);
        r7_dist  <= w_dist;
        r7_depth <= DEPTH_W'(w_rsum - w_dist);
        r7_hit   <= w_hit;
        r7_dz0   <= (w_dist == '0);
        r7_sgx   <= w_sgx;
        r7_sgy   <= w_sgy;
        r7_sgz   <= w_sgz;
        r7_mx    <= w_mx;
        r7_my    <= w_my;
        r7_mz    <= w_mz;
    end

    // normal dividers
    logic [Q_W-1:0]       w_qx, w_qy, w_qz;
    logic [PX_W-1:0]      w_px;
    logic                 w_fhit, w_fdz0, w_fsgx, w_fsgy, w_fsgz;
    logic [DEPTH_W-1:0]   w_fdepth;
    logic signed [CW-1:0] w_fmx, w_fmy, w_fmz;

    cpc_div #(.NUM_W(NUM_W), .DEN_W(DIST_W), .Q_W(Q_W), .PASS_W(PX_W)) u_div_x (
        .i_clk  (i_clk),
        .i_num  (r7_nx),
        .i_den  (r7_dist),
        .i_pass ({r7_hit, r7_dz0, r7_sgx, r7_depth, r7_mx, r7_my, r7_mz}),
        .o_quo  (w_qx),
        .o_pass (w_px)
    );

    cpc_div #(.NUM_W(NUM_W), .DEN_W(DIST_W), .Q_W(Q_W), .PASS_W(1)) u_div_y (
        .i_clk  (i_clk),
        .i_num  (r7_ny),
        .i_den  (r7_dist),
        .i_pass (r7_sgy),
        .o_quo  (w_qy),
        .o_pass (w_fsgy)
    );

    cpc_div #(.NUM_W(NUM_W), .DEN_W(DIST_W), .Q_W(Q_W), .PASS_W(1)) u_div_z (
        .i_clk  (i_clk),
        .i_num  (r7_nz),
        .i_den  (r7_dist),
        .i_pass (r7_sgz),
        .o_quo  (w_qz),
        .o_pass (w_fsgz)
    );

    assign {w_fhit, w_fdz0, w_fsgx, w_fdepth, w_fmx, w_fmy, w_fmz} = w_px;

    // material mixing: friction root, then restitution root
    logic [MIX_RT_W-1:0] w_froot, w_froot_d, w_rroot;
    logic [MIX_W-1:0]    w_rp_d;
    logic [2*MIX_RT_W-1:0] r_mix [MIX_DLY];

    cpc_isqrt #(.W(MIX_W), .PASS_W(MIX_W)) u_mix_f (
        .i_clk  (i_clk),
        .i_rad  (r1_fp),
        .i_pass (r1_rp),
        .o_root (w_froot),
        .o_pass (w_rp_d)
    );

    cpc_isqrt #(.W(MIX_W), .PASS_W(MIX_RT_W)) u_mix_r (
        .i_clk  (i_clk),
        .i_rad  (w_rp_d),
        .i_pass (w_froot),
        .o_root (w_rroot),
        .o_pass (w_froot_d)
    );

    always_ff @(posedge i_clk) begin
        r_mix[0] <= {w_rroot, w_froot_d};
        for (int i = 1; i < MIX_DLY; i++) r_mix[i] <= r_mix[i-1];
    end

    // output register
    logic [NORM_W-1:0] n_nx, n_ny, n_nz;

    always_comb begin
        n_nx = w_fsgx ? (NORM_W'(0) - NORM_W'(w_qx)) : NORM_W'(w_qx);
        n_ny = w_fsgy ? (NORM_W'(0) - NORM_W'(w_qy)) : NORM_W'(w_qy);
        n_nz = w_fsgz ? (NORM_W'(0) - NORM_W'(w_qz)) : NORM_W'(w_qz);
        if (w_fdz0) begin
            n_nx = '0;
            n_ny = '0;
            n_nz = '0;
        end
    end

    logic                 r_hit;
    logic [NORM_W-1:0]    r_nx, r_ny, r_nz;
    logic signed [CW-1:0] r_cx, r_cy, r_cz;
    logic [DEPTH_W-1:0]   r_depth;
    logic [HALF_W-1:0]    r_mf, r_mr;

    always_ff @(posedge i_clk) begin
        r_hit <= w_fhit;
        if (w_fhit) begin
            r_nx    <= n_nx;
            r_ny    <= n_ny;
            r_nz    <= n_nz;
            r_cx    <= w_fmx;
            r_cy    <= w_fmy;
            r_cz    <= w_fmz;
            r_depth <= w_fdepth;
            r_mf    <= r_mix[MIX_DLY-1][MIX_RT_W-1:0];
            r_mr    <= r_mix[MIX_DLY-1][2*MIX_RT_W-1:MIX_RT_W];
        end else begin
            r_nx    <= '0;
            r_ny    <= '0;
            r_nz    <= '0;
            r_cx    <= '0;
            r_cy    <= '0;
            r_cz    <= '0;
            r_depth <= '0;
            r_mf    <= '0;
            r_mr    <= '0;
        end
    end

    assign o_strobe            = r_vld[LAT-1];
    assign o_hit               = r_hit && r_vld[LAT-1];
    assign o_normal_x          = r_nx;
    assign o_normal_y          = r_ny;
    assign o_normal_z          = r_nz;
    assign o_contact_x         = r_cx;
    assign o_contact_y         = r_cy;
    assign o_contact_z         = r_cz;
    assign o_depth             = r_depth;
    assign o_mixed_friction    = r_mf;
    assign o_mixed_restitution = r_mr;

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_strobe)
        else $error("result strobe missing after input transfer");

    a_depth_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hit |-> (o_depth != '0))
        else $error("contact with zero depth");

    a_hit_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hit |-> o_strobe)
        else $error("hit outside result cycle");
`endif

endmodule

// ===== sv/cpc_isqrt.sv =====
// cpc_isqrt: pipelined integer square root, one result bit per stage.
// Carries a sideband word alongside; no package dependency.
module cpc_isqrt #(
    parameter int W      = 62,
    parameter int PASS_W = 1
) (
    input  logic              i_clk,
    input  logic [W-1:0]      i_rad,
    input  logic [PASS_W-1:0] i_pass,
    output logic [W/2-1:0]    o_root,
    output logic [PASS_W-1:0] o_pass
);

    localparam int S = W / 2;

    logic [W-1:0]      r_x [S];
    logic [W-1:0]      r_r [S];
    logic [PASS_W-1:0] r_p [S];

    for (genvar s = 0; s < S; s++) begin : g_stg
        localparam logic [W:0] BIT = (W+1)'(1) << (W - 2 - 2*s);
        logic [W-1:0]      x_in;
        logic [W-1:0]      rt_in;
        logic [PASS_W-1:0] p_in;
        logic [W:0]        trial;
        logic [W-1:0]      n_x;
        logic [W-1:0]      n_r;

        if (s == 0) begin : g_first
            assign x_in  = i_rad;
            assign rt_in = '0;
            assign p_in  = i_pass;
        end else begin : g_next
            assign x_in  = r_x[s-1];
            assign rt_in = r_r[s-1];
            assign p_in  = r_p[s-1];
        end

        assign trial = {1'b0, rt_in} + BIT;

        always_comb begin
            if ({1'b0, x_in} >= trial) begin
                n_x = x_in - trial[W-1:0];
                n_r = (rt_in >> 1) + BIT[W-1:0];
            end else begin
                n_x = x_in;
                n_r = rt_in >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            r_x[s] <= n_x;
            r_r[s] <= n_r;
            r_p[s] <= p_in;
        end
    end

    assign o_root = r_r[S-1][W/2-1:0];
    assign o_pass = r_p[S-1];

endmodule

// ===== sv/cpc_div.sv =====
// cpc_div: pipelined restoring divider, one quotient bit per stage.
// Quotient must fit Q_W bits; carries a sideband word; no package dependency.
module cpc_div #(
    parameter int NUM_W  = 48,
    parameter int DEN_W  = 31,
    parameter int Q_W    = 17,
    parameter int PASS_W = 1
) (
    input  logic              i_clk,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [PASS_W-1:0] i_pass,
    output logic [Q_W-1:0]    o_quo,
    output logic [PASS_W-1:0] o_pass
);

    logic [NUM_W-1:0]  r_rem [Q_W];
    logic [DEN_W-1:0]  r_den [Q_W];
    logic [Q_W-1:0]    r_q   [Q_W];
    logic [PASS_W-1:0] r_p   [Q_W];

    for (genvar s = 0; s < Q_W; s++) begin : g_stg
        localparam int K = Q_W - 1 - s;
        logic [NUM_W-1:0]  rem_in;
        logic [DEN_W-1:0]  den_in;
        logic [Q_W-1:0]    q_in;
        logic [PASS_W-1:0] p_in;
        logic [NUM_W-1:0]  sub;
        logic [NUM_W-1:0]  n_rem;
        logic [Q_W-1:0]    n_q;

        if (s == 0) begin : g_first
            assign rem_in = i_num;
            assign den_in = i_den;
            assign q_in   = '0;
            assign p_in   = i_pass;
        end else begin : g_next
            assign rem_in = r_rem[s-1];
            assign den_in = r_den[s-1];
            assign q_in   = r_q[s-1];
            assign p_in   = r_p[s-1];
        end

        assign sub = NUM_W'(den_in) << K;

        always_comb begin
            if (rem_in >= sub) begin
                n_rem = rem_in - sub;
                n_q   = q_in | (Q_W'(1) << K);
            end else begin
                n_rem = rem_in;
                n_q   = q_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[s] <= n_rem;
            r_den[s] <= den_in;
            r_q[s]   <= n_q;
            r_p[s]   <= p_in;
        end
    end

    assign o_quo  = r_q[Q_W-1];
    assign o_pass = r_p[Q_W-1];

endmodule

// ===== tb/sv/capsule_pair_contact_top_tb.sv =====
// Self-checking bench for capsule_pair_contact_top: directed table, then random pairs.
// Typed or in-bench predicted expectations are compared with strobed results in order.
// Depends on cpc_pkg and capsule_pair_contact_top.
module capsule_pair_contact_top_tb;
    import cpc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB = 32;
    localparam int FB = 16;
    localparam int LATENCY = 40 + FB;

    typedef struct packed {
        logic signed [CB-1:0] ax, ay, az, bx, by, bz;
        logic [LEN_W-1:0]     ha, hb, ra, rb;
        logic [PAIR_W-1:0]    fr, rs;
    } t_pair;

    typedef struct packed {
        logic                     hit;
        logic signed [NORM_W-1:0] nx, ny, nz;
        logic signed [CB-1:0]     cx, cy, cz;
        logic [DEPTH_W-1:0]       depth;
        logic [HALF_W-1:0]        mf, mr;
    } t_contact;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_pair drv = '0;
    logic o_strobe, o_hit;
    logic signed [NORM_W-1:0] o_normal_x, o_normal_y, o_normal_z;
    logic signed [CB-1:0] o_contact_x, o_contact_y, o_contact_z;
    logic [DEPTH_W-1:0] o_depth;
    logic [HALF_W-1:0] o_mixed_friction, o_mixed_restitution;

    t_contact expected_contacts[$];
    int errors = 0;
    int idle_pct = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    capsule_pair_contact_top #(.COORD_BITS(CB), .FRAC_BITS(FB)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_a_base_x(drv.ax), .i_a_base_y(drv.ay), .i_a_base_z(drv.az),
        .i_b_base_x(drv.bx), .i_b_base_y(drv.by), .i_b_base_z(drv.bz),
        .i_a_height(drv.ha), .i_b_height(drv.hb), .i_a_radius(drv.ra), .i_b_radius(drv.rb),
        .i_friction_pair(drv.fr), .i_restitution_pair(drv.rs),
        .o_strobe(o_strobe), .o_hit(o_hit),
        .o_normal_x(o_normal_x), .o_normal_y(o_normal_y), .o_normal_z(o_normal_z),
        .o_contact_x(o_contact_x), .o_contact_y(o_contact_y), .o_contact_z(o_contact_z),
        .o_depth(o_depth), .o_mixed_friction(o_mixed_friction),
        .o_mixed_restitution(o_mixed_restitution)
    );

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint clampl(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint unsigned mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic logic [NORM_W-1:0] unit_comp(longint d, longint unsigned dlen);
        longint unsigned m;
        if (dlen == 0) return '0;
        m = ((mag(d) << FB) + dlen / 2) / dlen;
        if (d < 0) m = -m;
        return m[NORM_W-1:0];
    endfunction

    function automatic logic [CB-1:0] midpoint(longint p, longint q);
        longint s, h;
        s = p + q;
        h = s >>> 1;
        return CB'(clampl(h, -(64'sd1 << (CB - 1)), (64'sd1 << (CB - 1)) - 1));
    endfunction

    function automatic logic [HALF_W-1:0] geo_mean(logic [PAIR_W-1:0] p);
        longint unsigned v;
        v = int_sqrt(longint'(p[15:0]) * longint'(p[31:16]));
        return v[HALF_W-1:0];
    endfunction

    function automatic t_contact predict_contact(t_pair p);
        t_contact c;
        longint ax, ay, az, bx, by, bz, u, cay, cby, dx, dy, dz;
        longint unsigned rsum, sq, dlen;
        c = '0;
        ax = p.ax; ay = p.ay; az = p.az; bx = p.bx; by = p.by; bz = p.bz;
        rsum = longint'(p.ra) + longint'(p.rb);
        u = by - ay;
        cay = ay + clampl(u, 0, p.ha);
        cby = by + clampl(-u, 0, p.hb);
        dx = bx - ax; dy = cby - cay; dz = bz - az;
        if (mag(dx) >= rsum || mag(dy) >= rsum || mag(dz) >= rsum) return c;
        sq = mag(dx) * mag(dx) + mag(dy) * mag(dy) + mag(dz) * mag(dz);
        if (sq >= rsum * rsum) return c;
        dlen = int_sqrt(sq);
        c.hit = 1'b1;
        c.nx = unit_comp(dx, dlen);
        c.ny = unit_comp(dy, dlen);
        c.nz = unit_comp(dz, dlen);
        c.cx = midpoint(ax, bx);
        c.cy = midpoint(cay, cby);
        c.cz = midpoint(az, bz);
        c.depth = DEPTH_W'(rsum - dlen);
        c.mf = geo_mean(p.fr);
        c.mr = geo_mean(p.rs);
        return c;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_contact g, e;
        if (i_rst_n && o_strobe) begin
            g = '{o_hit, o_normal_x, o_normal_y, o_normal_z, o_contact_x, o_contact_y,
                  o_contact_z, o_depth, o_mixed_friction, o_mixed_restitution};
            if (expected_contacts.size() == 0) begin
                report_mismatch("unexpected result, hit", g.hit, 0);
            end else begin
                e = expected_contacts.pop_front();
                if (g.hit != e.hit) report_mismatch("hit", g.hit, e.hit);
                if (g.nx != e.nx) report_mismatch("normal_x", g.nx, e.nx);
                if (g.ny != e.ny) report_mismatch("normal_y", g.ny, e.ny);
                if (g.nz != e.nz) report_mismatch("normal_z", g.nz, e.nz);
                if (g.cx != e.cx) report_mismatch("contact_x", g.cx, e.cx);
                if (g.cy != e.cy) report_mismatch("contact_y", g.cy, e.cy);
                if (g.cz != e.cz) report_mismatch("contact_z", g.cz, e.cz);
                if (g.depth != e.depth) report_mismatch("depth", g.depth, e.depth);
                if (g.mf != e.mf) report_mismatch("mixed_friction", g.mf, e.mf);
                if (g.mr != e.mr) report_mismatch("mixed_restitution", g.mr, e.mr);
            end
        end
    end

    // one transfer; expectation queued at the accepting edge
    task automatic send_pair(t_pair p, t_contact want, bit typed);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        drv <= p;
        do @(posedge i_clk); while (busy);
        expected_contacts.push_back(typed ? want : predict_contact(p));
    endtask

    function automatic logic [CB-1:0] rand_coord(int span);
        logic [CB-1:0] v;
        case ($urandom_range(9))
            0: v = $urandom();
            1: v = $urandom_range(1) ? 32'h7fff_ffff - $urandom_range(span)
                                     : 32'h8000_0000 + $urandom_range(span);
            default: v = $urandom_range(2 * span) - span;
        endcase
        return v;
    endfunction

    function automatic logic [LEN_W-1:0] rand_len(int span);
        case ($urandom_range(9))
            0: return '0;
            1: return LEN_W'($urandom());
            2: return LEN_W'({LEN_W{1'b1}} - $urandom_range(3));
            default: return LEN_W'($urandom_range(span));
        endcase
    endfunction

    function automatic t_pair rand_pair();
        t_pair p;
        int span;
        span = 1 << $urandom_range(20, 8);
        p.ax = rand_coord(span); p.ay = rand_coord(span); p.az = rand_coord(span);
        // mostly near A so contacts are common
        p.bx = ($urandom_range(3) != 0) ? p.ax + $urandom_range(2 * span) - span
                                        : rand_coord(span);
        p.by = ($urandom_range(3) != 0) ? p.ay + $urandom_range(4 * span) - 2 * span
                                        : rand_coord(span);
        p.bz = ($urandom_range(3) != 0) ? p.az + $urandom_range(2 * span) - span
                                        : rand_coord(span);
        p.ha = rand_len(2 * span); p.hb = rand_len(2 * span);
        p.ra = rand_len(span); p.rb = rand_len(span);
        p.fr = $urandom(); p.rs = $urandom();
        return p;
    endfunction

    initial begin
        t_pair dir_pairs[$];
        t_contact dir_want[$];
        bit dir_typed[$];
        t_contact miss, z;
        t_pair p;
        int n;
        miss = '0;
        z = '0;
        p = '0;
        // coincident capsules at origin: zero normal, depth = radius sum
        p.ra = 30'd100; p.rb = 30'd50; p.fr = 32'h0004_0004; p.rs = 32'h0009_0001;
        z = '{1'b1, '0, '0, '0, '0, '0, '0, 31'd150, 16'd4, 16'd3};
        dir_pairs.push_back(p); dir_want.push_back(z); dir_typed.push_back(1);
        p = '0;                                   // zero radius sum
        dir_pairs.push_back(p); dir_want.push_back(miss); dir_typed.push_back(1);
        p.ra = '1; p.rb = '1; p.fr = '1; p.rs = '1;   // extreme radii, full pairs
        dir_pairs.push_back(p); dir_want.push_back(miss); dir_typed.push_back(0);
        p = '0; p.ax = 32'h8000_0000; p.bx = 32'h7fff_ffff; p.ra = 30'd5;
        dir_pairs.push_back(p); dir_want.push_back(miss); dir_typed.push_back(1);
        p = '0; p.ax = 32'h8000_0000; p.bx = 32'h8000_0000; p.ay = 32'h8000_0000;
        p.by = 32'h8000_0000; p.az = 32'h8000_0000; p.bz = 32'h8000_0000; p.ra = 30'd7;
        dir_pairs.push_back(p); dir_want.push_back(miss); dir_typed.push_back(0);
        p.ax = 32'h7fff_ffff; p.bx = 32'h7fff_ffff; p.ay = 32'h7fff_ffff;
        p.by = 32'h7fff_ffff; p.az = 32'h7fff_ffff; p.bz = 32'h7fff_ffff;
        p.ha = '1; p.hb = '1;
        dir_pairs.push_back(p); dir_want.push_back(miss); dir_typed.push_back(0);
        p = '0; p.by = 32'h0010_0000; p.ha = 30'h0008_0000; p.ra = 30'h0010_0000;
        dir_pairs.push_back(p); dir_want.push_back(miss); dir_typed.push_back(0);
        p = '0; p.ay = 32'h0010_0000; p.hb = 30'h0008_0000; p.rb = 30'h0010_0000;
        dir_pairs.push_back(p); dir_want.push_back(miss); dir_typed.push_back(0);
        p = '0; p.ay = 32'h0010_0000; p.hb = '0; p.rb = 30'h0010_0000;   // zero B height
        dir_pairs.push_back(p); dir_want.push_back(miss); dir_typed.push_back(0);
        p = '0; p.bx = 32'h0001_0000; p.bz = 32'hffff_0000; p.ra = 30'h0001_0000;
        p.rb = 30'h0001_0000; p.fr = 32'hffff_ffff; p.rs = 32'h0000_ffff;
        dir_pairs.push_back(p); dir_want.push_back(miss); dir_typed.push_back(0);
        p = '0; p.bx = 32'd3; p.by = 32'hffff_fffc; p.ra = 30'd3; p.rb = 30'd2;
        dir_pairs.push_back(p); dir_want.push_back(miss); dir_typed.push_back(0);
        p = '0; p.ax = 32'h7fff_fff0; p.bx = 32'h7fff_ffff; p.ay = 32'h8000_0000;
        p.by = 32'h8000_0001; p.ra = '1; p.fr = 32'hffff_0001;
        dir_pairs.push_back(p); dir_want.push_back(miss); dir_typed.push_back(0);
        p = '0; p.ax = 32'hffff_fffd; p.bx = 32'd4; p.ra = 30'd8;   // odd x sum, negative A x
        dir_pairs.push_back(p); dir_want.push_back(miss); dir_typed.push_back(0);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (dir_pairs[k]) send_pair(dir_pairs[k], dir_want[k], dir_typed[k]);
        start <= 1'b0;
        // hold off until the pipeline drains
        while (expected_contacts.size() != 0) @(posedge i_clk);
        for (n = 0; n < 1750; n++) begin
            idle_pct = (n < 600) ? 9 : (n < 1200) ? 62 : 0;
            send_pair(rand_pair(), miss, 0);
        end
        start <= 1'b0;
        while (expected_contacts.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
        if (errors == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #200000;
        $display("*** FAILED ***");
        $finish;
    end
endmodule

// ===== capsule_pair_contact_top.f =====
sv/cpc_pkg.sv
sv/cpc_isqrt.sv
sv/cpc_div.sv
sv/capsule_pair_contact_top.sv
tb/sv/capsule_pair_contact_top_tb.sv
